// File: rtl/vwnf_pkg.sv
// Shared types, constants and helper functions for the voxel walkable neighbor finder.
// No dependencies; every other file of the block imports this package.
package vwnf_pkg;

  localparam int unsigned X_W         = 6;
  localparam int unsigned Z_W         = 6;
  localparam int unsigned Y_W         = 5;
  localparam int unsigned GRID_X      = 64;
  localparam int unsigned GRID_Z      = 64;
  localparam int unsigned GRID_HEIGHT = 32;
  localparam int unsigned UP_SPAN     = 7;
  localparam int unsigned NUM_NB      = 8;
  localparam int unsigned NB_W        = 3;
  localparam int unsigned ADDR_W      = X_W + Z_W;
  localparam int unsigned DEPTH       = 1 << ADDR_W;
  localparam int unsigned MC_W        = 3;
  localparam int unsigned MH_W        = 3;
  localparam int unsigned MD_W        = 5;
  localparam int unsigned PADDR_W     = 4;
  localparam int unsigned PDATA_W     = 32;

  localparam logic [X_W-1:0]    X_MAX   = X_W'(GRID_X - 1);
  localparam logic [Z_W-1:0]    Z_MAX   = Z_W'(GRID_Z - 1);
  localparam logic [NB_W-1:0]   NB_LAST = NB_W'(NUM_NB - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);

  localparam logic [1:0] REG_MIN_CLEARANCE = 2'd0;
  localparam logic [1:0] REG_MAX_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_MAX_DROP      = 2'd2;

  localparam logic [MC_W-1:0] MC_RESET = MC_W'(1);
  localparam logic [MH_W-1:0] MH_RESET = MH_W'(1);
  localparam logic [MD_W-1:0] MD_RESET = MD_W'(3);

  typedef enum logic [1:0] {
    OP_ADD,
    OP_REMOVE,
    OP_PROBE,
    OP_QUERY
  } op_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_RMW,
    BK_PROBE,
    BK_CENTER,
    BK_NBDATA,
    BK_EMIT,
    BK_FINISH
  } back_state_e;

  typedef struct packed {
    op_e            op;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic [Z_W-1:0] z;
  } cmd_t;

  typedef struct packed {
    logic           found;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic [Z_W-1:0] z;
    logic           last;
  } result_t;

  typedef struct packed {
    logic [MC_W-1:0] min_clearance;
    logic [MH_W-1:0] max_height;
    logic [MD_W-1:0] max_drop;
  } cfg_t;

  // Neighbor visiting order, as (dx,dz) steps of -1, 0 or +1.
  function automatic logic signed [1:0] nb_dx(input logic [NB_W-1:0] k);
    logic signed [1:0] d;
    unique case (k)
      3'd0, 3'd3, 3'd5: d = -2'sd1;
      3'd1, 3'd6:       d = 2'sd0;
      default:          d = 2'sd1;
    endcase
    return d;
  endfunction

  function automatic logic signed [1:0] nb_dz(input logic [NB_W-1:0] k);
    logic signed [1:0] d;
    unique case (k)
      3'd0, 3'd1, 3'd2: d = 2'sd1;
      3'd3, 3'd4:       d = 2'sd0;
      default:          d = -2'sd1;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/voxel_walkable_neighbor_finder_unit.sv
// Top level of the voxel walkable neighbor finder: configuration registers and the
// front stage, command queue and execution engine. Depends on vwnf_pkg and its submodules.
//
// Usage:
// - Input channel (in_valid_i/in_stall_o) carries one transaction per command: add, remove,
//   probe or neighbor query on the occupancy grid held in a 4096 x 32 column memory.
// - Output channel (out_valid_o/out_stall_i) carries result transactions; last_o marks the
//   final result of a command. Add and remove give none, a probe gives one, a query gives
//   zero to 64 results.
// - After reset the engine clears the column memory, one column per cycle; in_stall_o is high
//   during that pass. Configuration writes are taken at any time but must only be issued
//   while the block is idle.
// - Add and remove are a read-modify-write of one column in the engine. A probe result
//   passes through the input slot, the command queue, a memory read and the output register.
// - A query reads the centre column and then one neighbor column per cycle from the single
//   read port, pausing while the results of a column are emitted. The last result of a
//   query leaves once the final column has been examined.
// - A stalled output holds its result; the engine waits, while the input stage and the
//   two-entry command queue keep taking transactions until they are full.
module voxel_walkable_neighbor_finder_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   opcode_i,
  input  logic [vwnf_pkg::X_W-1:0]     cell_x_i,
  input  logic [vwnf_pkg::Y_W-1:0]     cell_y_i,
  input  logic [vwnf_pkg::Z_W-1:0]     cell_z_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         node_found_o,
  output logic [vwnf_pkg::X_W-1:0]     node_x_o,
  output logic [vwnf_pkg::Y_W-1:0]     node_y_o,
  output logic [vwnf_pkg::Z_W-1:0]     node_z_o,
  output logic                         last_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vwnf_pkg::PADDR_W-1:0] paddr,
  input  logic [vwnf_pkg::PDATA_W-1:0] pwdata,
  output logic [vwnf_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import vwnf_pkg::*;

  cfg_t    cfg_q, cfg_d;
  logic    cfg_wr;
  logic    clearing;
  logic    push_valid;
  cmd_t    push_cmd;
  logic    push_ready;
  logic    head_valid;
  cmd_t    head_cmd;
  logic    pop;
  result_t res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MIN_CLEARANCE: cfg_d.min_clearance = pwdata[MC_W-1:0];
        REG_MAX_HEIGHT:    cfg_d.max_height    = pwdata[MH_W-1:0];
        REG_MAX_DROP:      cfg_d.max_drop      = pwdata[MD_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MIN_CLEARANCE: prdata = PDATA_W'(cfg_q.min_clearance);
      REG_MAX_HEIGHT:    prdata = PDATA_W'(cfg_q.max_height);
      REG_MAX_DROP:      prdata = PDATA_W'(cfg_q.max_drop);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_clearance <= MC_RESET;
      cfg_q.max_height    <= MH_RESET;
      cfg_q.max_drop      <= MD_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  vwnf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .cell_x_i     (cell_x_i),
    .cell_y_i     (cell_y_i),
    .cell_z_i     (cell_z_i),
    .clearing_i   (clearing),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd),
    .push_ready_i (push_ready)
  );

  vwnf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd),
    .pop_i        (pop)
  );

  vwnf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_cmd_i   (head_cmd),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_o        (res)
  );

  assign node_found_o = res.found;
  assign node_x_o     = res.x;
  assign node_y_o     = res.y;
  assign node_z_o     = res.z;
  assign last_o       = res.last;

endmodule

// File: rtl/vwnf_front.sv
// Input stage: accepts transactions, decodes the opcode and hands commands to the queue.
// Depends on vwnf_pkg.
module vwnf_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               opcode_i,
  input  logic [vwnf_pkg::X_W-1:0] cell_x_i,
  input  logic [vwnf_pkg::Y_W-1:0] cell_y_i,
  input  logic [vwnf_pkg::Z_W-1:0] cell_z_i,
  input  logic                     clearing_i,
  output logic                     push_valid_o,
  output vwnf_pkg::cmd_t           push_cmd_o,
  input  logic                     push_ready_i
);
  import vwnf_pkg::*;

  logic slot_vld_q, slot_vld_d;
  cmd_t slot_q;
  logic accept;
  logic pushed;

  assign in_stall_o   = clearing_i || (slot_vld_q && !push_ready_i);
  assign accept       = in_valid_i && !in_stall_o;
  assign pushed       = slot_vld_q && push_ready_i;
  assign push_valid_o = slot_vld_q;
  assign push_cmd_o   = slot_q;

  always_comb begin
    slot_vld_d = slot_vld_q;
    if (accept) begin
      slot_vld_d = 1'b1;
    end else if (pushed) begin
      slot_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= 1'b0;
    end else begin
      slot_vld_q <= slot_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q.op <= op_e'(opcode_i);
      slot_q.x  <= cell_x_i;
      slot_q.y  <= cell_y_i;
      slot_q.z  <= cell_z_i;
    end
  end

endmodule

// File: rtl/vwnf_queue.sv
// Two-entry command queue between the input stage and the execution engine.
// Depends on vwnf_pkg.
module vwnf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  vwnf_pkg::cmd_t push_cmd_i,
  output logic           push_ready_o,
  output logic           head_valid_o,
  output vwnf_pkg::cmd_t head_cmd_o,
  input  logic           pop_i
);
  import vwnf_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  logic       pop;

  assign push_ready_o = (count_q != 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_cmd_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// File: rtl/vwnf_back.sv
// Execution engine: occupancy column memory, command sequencer and result output register.
// Depends on vwnf_pkg.
module vwnf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  vwnf_pkg::cfg_t cfg_i,
  input  logic           head_valid_i,
  input  vwnf_pkg::cmd_t head_cmd_i,
  output logic           pop_o,
  output logic           clearing_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output vwnf_pkg::result_t out_o
);
  import vwnf_pkg::*;

  back_state_e state_q, state_d;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  cmd_t              cur_q, cur_d;
  logic [NB_W-1:0]   k_q, k_d;
  logic              last_col_q, last_col_d;
  logic [UP_SPAN-1:0] up_q, up_d;
  logic              drop_vld_q, drop_vld_d;
  logic [Y_W-1:0]    drop_y_q, drop_y_d;
  logic [X_W-1:0]    ex_x_q, ex_x_d;
  logic [Z_W-1:0]    ex_z_q, ex_z_d;
  logic              hold_vld_q, hold_vld_d;
  result_t           hold_q, hold_d;
  logic              out_vld_q, out_vld_d;
  result_t           out_q, out_d;

  logic [GRID_HEIGHT-1:0] mem [DEPTH];
  logic [GRID_HEIGHT-1:0] rdata_q;
  logic [X_W-1:0]         col_x_q;
  logic [Z_W-1:0]         col_z_q;
  logic                   col_in_q;
  logic                   rd_en;
  logic [X_W-1:0]         rd_x;
  logic [Z_W-1:0]         rd_z;
  logic                   rd_in;
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic [GRID_HEIGHT-1:0] wr_data;

  logic [NB_W-1:0]   sel_k;
  logic signed [1:0] dx;
  logic signed [1:0] dz;
  logic [X_W-1:0]    nb_x;
  logic [Z_W-1:0]    nb_z;
  logic              nb_in;

  logic [GRID_HEIGHT-1:0]       col;
  logic [GRID_HEIGHT+UP_SPAN-1:0] shifted;
  logic [UP_SPAN-1:0]           win;
  logic [3:0]                   span_sum;
  logic [3:0]                   span;
  logic [UP_SPAN-1:0]           up_emit;
  logic                         can_drop;
  logic                         drop_found;
  logic [Y_W-1:0]               drop_y;
  logic                         out_ready;
  logic                         can_take;
  logic [Y_W-1:0]               up_top;
  logic [UP_SPAN-1:0]           up_top_bit;
  result_t                      new_res;

  assign out_ready   = !out_vld_q || !out_stall_i;
  assign can_take    = !hold_vld_q || out_ready;
  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;
  assign clearing_o  = (state_q == BK_CLEAR);

  // Neighbor column coordinates, with a flag for columns that fall off the grid.
  always_comb begin
    dx    = nb_dx(sel_k);
    dz    = nb_dz(sel_k);
    nb_x  = cur_q.x + {{(X_W-2){dx[1]}}, dx};
    nb_z  = cur_q.z + {{(Z_W-2){dz[1]}}, dz};
    nb_in = !((dx == -2'sd1) && (cur_q.x == '0)) && !((dx == 2'sd1) && (cur_q.x == X_MAX)) &&
            !((dz == -2'sd1) && (cur_q.z == '0)) && !((dz == 2'sd1) && (cur_q.z == Z_MAX));
  end

  // Column classification: walkable heights at or above the centre and the first drop below.
  always_comb begin
    logic ok;
    col      = col_in_q ? rdata_q : '0;
    shifted  = {{UP_SPAN{1'b0}}, col} >> cur_q.y;
    win      = shifted[UP_SPAN-1:0];
    span_sum = {1'b0, cfg_i.max_height} + {1'b0, cfg_i.min_clearance};
    span     = (span_sum > 4'(UP_SPAN - 1)) ? 4'(UP_SPAN - 1) : span_sum;
    can_drop = 1'b1;
    for (int h = 0; h < UP_SPAN; h++) begin
      ok = win[h] && ((4'(h) + {1'b0, cfg_i.min_clearance}) <= span);
      for (int j = 1; h + j < UP_SPAN; j++) begin
        if ((4'(j) <= {1'b0, cfg_i.min_clearance}) && win[h+j]) begin
          ok = 1'b0;
        end
      end
      up_emit[h] = ok;
      if (win[h] && (4'(h) < {1'b0, cfg_i.min_clearance}) && (4'(h) <= span)) begin
        can_drop = 1'b0;
      end
    end
    drop_found = 1'b0;
    drop_y     = '0;
    for (int y = 0; y < GRID_HEIGHT; y++) begin
      if (col[y] && ({1'b0, 5'(y)} < {1'b0, cur_q.y}) &&
          (({1'b0, 5'(y)} + {1'b0, cfg_i.max_drop}) > {1'b0, cur_q.y})) begin
        drop_found = 1'b1;
        drop_y     = Y_W'(y);
      end
    end
  end

  // Highest pending walkable height of the column being emitted.
  always_comb begin
    up_top     = '0;
    up_top_bit = '0;
    for (int h = 0; h < UP_SPAN; h++) begin
      if (up_q[h]) begin
        up_top     = Y_W'(h);
        up_top_bit = UP_SPAN'(1) << h;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    cur_d      = cur_q;
    k_d        = k_q;
    last_col_d = last_col_q;
    up_d       = up_q;
    drop_vld_d = drop_vld_q;
    drop_y_d   = drop_y_q;
    ex_x_d     = ex_x_q;
    ex_z_d     = ex_z_q;
    hold_vld_d = hold_vld_q;
    hold_d     = hold_q;
    out_vld_d  = out_vld_q && out_stall_i;
    out_d      = out_q;
    pop_o      = 1'b0;
    rd_en      = 1'b0;
    sel_k      = k_q;
    rd_x       = nb_x;
    rd_z       = nb_z;
    rd_in      = nb_in;
    wr_en      = 1'b0;
    wr_addr    = {cur_q.x, cur_q.z};
    wr_data    = '0;
    new_res    = '0;

    unique case (state_q)
      BK_CLEAR: begin
        wr_en     = 1'b1;
        wr_addr   = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == ADDR_LAST) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        rd_x  = head_cmd_i.x;
        rd_z  = head_cmd_i.z;
        rd_in = 1'b1;
        if (head_valid_i) begin
          pop_o = 1'b1;
          rd_en = 1'b1;
          cur_d = head_cmd_i;
          unique case (head_cmd_i.op)
            OP_ADD, OP_REMOVE: state_d = BK_RMW;
            OP_PROBE:          state_d = BK_PROBE;
            OP_QUERY:          state_d = BK_CENTER;
          endcase
        end
      end
      BK_RMW: begin
        wr_en = 1'b1;
        if (cur_q.op == OP_ADD) begin
          wr_data = rdata_q | (GRID_HEIGHT'(1) << cur_q.y);
        end else begin
          wr_data = rdata_q & ~(GRID_HEIGHT'(1) << cur_q.y);
        end
        state_d = BK_IDLE;
      end
      BK_PROBE: begin
        if (out_ready) begin
          out_vld_d   = 1'b1;
          out_d.found = rdata_q[cur_q.y];
          out_d.x     = cur_q.x;
          out_d.y     = cur_q.y;
          out_d.z     = cur_q.z;
          out_d.last  = 1'b1;
          state_d     = BK_IDLE;
        end
      end
      BK_CENTER: begin
        if (rdata_q[cur_q.y]) begin
          sel_k   = '0;
          rd_en   = 1'b1;
          k_d     = '0;
          state_d = BK_NBDATA;
        end else begin
          state_d = BK_IDLE;
        end
      end
      BK_NBDATA: begin
        up_d       = up_emit;
        drop_vld_d = can_drop && drop_found;
        drop_y_d   = drop_y;
        ex_x_d     = col_x_q;
        ex_z_d     = col_z_q;
        last_col_d = (k_q == NB_LAST);
        if (k_q != NB_LAST) begin
          sel_k = k_q + 1'b1;
          rd_en = 1'b1;
          k_d   = k_q + 1'b1;
        end
        if ((|up_emit) || (can_drop && drop_found)) begin
          state_d = BK_EMIT;
        end else if (k_q == NB_LAST) begin
          state_d = BK_FINISH;
        end
      end
      BK_EMIT: begin
        new_res.found = 1'b1;
        new_res.x     = ex_x_q;
        new_res.z     = ex_z_q;
        new_res.last  = 1'b0;
        new_res.y     = (|up_q) ? (cur_q.y + up_top) : drop_y_q;
        if ((|up_q) || drop_vld_q) begin
          if (can_take) begin
            if (hold_vld_q) begin
              out_vld_d = 1'b1;
              out_d     = hold_q;
            end
            hold_vld_d = 1'b1;
            hold_d     = new_res;
            if (|up_q) begin
              up_d = up_q & ~up_top_bit;
            end else begin
              drop_vld_d = 1'b0;
            end
          end
        end else begin
          state_d = last_col_q ? BK_FINISH : BK_NBDATA;
        end
      end
      BK_FINISH: begin
        if (!hold_vld_q) begin
          state_d = BK_IDLE;
        end else if (out_ready) begin
          out_vld_d  = 1'b1;
          out_d      = hold_q;
          out_d.last = 1'b1;
          hold_vld_d = 1'b0;
          state_d    = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_CLEAR;
      clr_cnt_q  <= '0;
      k_q        <= '0;
      last_col_q <= 1'b0;
      up_q       <= '0;
      drop_vld_q <= 1'b0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_cnt_q  <= clr_cnt_d;
      k_q        <= k_d;
      last_col_q <= last_col_d;
      up_q       <= up_d;
      drop_vld_q <= drop_vld_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    drop_y_q <= drop_y_d;
    ex_x_q   <= ex_x_d;
    ex_z_q   <= ex_z_d;
    hold_q   <= hold_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q  <= mem[{rd_x, rd_z}];
      col_x_q  <= rd_x;
      col_z_q  <= rd_z;
      col_in_q <= rd_in;
    end
  end

endmodule
